// ----- rtl/spq_pkg.sv -----
`timescale 1ns / 1ps

package spq_pkg;

  localparam int FREQ_W          = 23;
  localparam int SLOT_W          = 7;
  localparam int KEY_W           = 4;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 23;
  localparam int TABLE_DEPTH_DEF = 128;
  localparam int FRAC_BITS_DEF   = 10;
  localparam int SEMI_PER_OCT    = 12;
  localparam int STEP_W          = 3;
  localparam int SCALE_STEPS     = 7;
  localparam int RATIO_FRAC      = 17;

  localparam logic [FREQ_W-1:0] MIN_FREQ_RST = FREQ_W'(20480);
  localparam logic [FREQ_W-1:0] MAX_FREQ_RST = FREQ_W'(1024000);

  // 55 * round(2^(k/12) * 2^16): 27.5 Hz times the semitone ratio, Q.17 scaled
  localparam logic [FREQ_W-1:0] NOTE_BASE [SEMI_PER_OCT] = '{
    23'd3604480, 23'd3818815, 23'd4045910, 23'd4286480,
    23'd4541350, 23'd4811400, 23'd5097510, 23'd5400615,
    23'd5721760, 23'd6061990, 23'd6422460, 23'd6804325
  };

  localparam logic [1:0] MAJOR_STEPS [SCALE_STEPS] = '{
    2'd2, 2'd2, 2'd1, 2'd2, 2'd2, 2'd2, 2'd1
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY_ROOT  = 2'd0,
    REG_CHROMATIC = 2'd1,
    REG_MIN_FREQ  = 2'd2,
    REG_MAX_FREQ  = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic start;
    logic adv;
    logic chromatic;
    logic [KEY_W-1:0] key_root;
  } gen_ctl_t;

endpackage

// ----- rtl/spq_if.sv -----
`timescale 1ns / 1ps

interface spq_pitch_if;
  import spq_pkg::*;
  logic              valid;
  logic              ready;
  logic [FREQ_W-1:0] pitch_in;
  modport source (output valid, output pitch_in, input ready);
  modport sink (input valid, input pitch_in, output ready);
endinterface

interface spq_note_if;
  import spq_pkg::*;
  logic              valid;
  logic              ready;
  logic [FREQ_W-1:0] note_freq;
  logic [SLOT_W-1:0] note_slot;
  logic              table_empty;
  modport source (output valid, output note_freq, output note_slot, output table_empty,
                  input ready);
  modport sink (input valid, input note_freq, input note_slot, input table_empty,
                output ready);
endinterface

interface spq_cfg_if;
  import spq_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- rtl/spq_ram.sv -----
`timescale 1ns / 1ps

module spq_ram #(
  parameter int WIDTH = 23,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/spq_note_gen.sv -----
`timescale 1ns / 1ps

module spq_note_gen #(
  parameter int FRAC_BITS = 10
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  spq_pkg::gen_ctl_t         ctl_i,
  output logic [spq_pkg::FREQ_W-1:0] freq_o,
  output logic                      ovf_o
);
  import spq_pkg::*;

  localparam int SH    = RATIO_FRAC - FRAC_BITS;
  localparam int OCT_W = $clog2(SH + 3);
  localparam int XW    = FREQ_W + SH + 2;
  localparam logic [XW-1:0] RND = XW'(1) << (SH - 1);

  logic [KEY_W-1:0]  semi_q, semi_d;
  logic [OCT_W-1:0]  oct_q, oct_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [KEY_W-1:0]  inc;
  logic [KEY_W-1:0]  sum;
  logic [XW-1:0]     shifted;
  logic [XW-1:0]     rounded;
  logic [FREQ_W+1:0] freq_wide;
  logic              oct_big;

  always_comb begin
    semi_d = semi_q;
    oct_d  = oct_q;
    step_d = step_q;
    inc    = ctl_i.chromatic ? KEY_W'(1) : KEY_W'(MAJOR_STEPS[step_q]);
    sum    = semi_q + inc;
    if (ctl_i.start) begin
      step_d = '0;
      if (ctl_i.key_root >= KEY_W'(SEMI_PER_OCT)) begin
        semi_d = ctl_i.key_root - KEY_W'(SEMI_PER_OCT);
        oct_d  = OCT_W'(1);
      end else begin
        semi_d = ctl_i.key_root;
        oct_d  = '0;
      end
    end else if (ctl_i.adv) begin
      step_d = (step_q == STEP_W'(SCALE_STEPS - 1)) ? '0 : step_q + STEP_W'(1);
      if (sum >= KEY_W'(SEMI_PER_OCT)) begin
        semi_d = sum - KEY_W'(SEMI_PER_OCT);
        oct_d  = oct_q + OCT_W'(1);
      end else begin
        semi_d = sum;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      semi_q <= '0;
      oct_q  <= '0;
      step_q <= '0;
    end else begin
      semi_q <= semi_d;
      oct_q  <= oct_d;
      step_q <= step_d;
    end
  end

  always_comb begin
    oct_big   = oct_q > OCT_W'(SH + 1);
    shifted   = XW'(NOTE_BASE[semi_q]) << oct_q;
    rounded   = shifted + RND;
    freq_wide = rounded[XW-1:SH];
    ovf_o     = oct_big || (|freq_wide[FREQ_W+1:FREQ_W]);
    freq_o    = freq_wide[FREQ_W-1:0];
  end

endmodule

// ----- rtl/scale_pitch_quantizer.sv -----
`timescale 1ns / 1ps

// Snaps a pitch word (unsigned Q13.10 Hz) to the nearest note of the major scale on
// key_root, or of the chromatic scale, between min_freq and max_freq; ties go up,
// a pitch above the top note gets the top note, and an empty table returns
// table_empty with zero payload. Any configuration write marks the note table
// stale; the next pitch word then first rebuilds it, one scale step per cycle
// through the single note generator, up to max_freq. A lookup is a binary search
// over the table RAM through its single registered read port: each probe sets the
// address in ST_SRCH and compares the returned note in ST_CMP. The input is ready
// only while no pitch is in work; a finished result waits in the output register.
module scale_pitch_quantizer #(
  parameter int TABLE_DEPTH = spq_pkg::TABLE_DEPTH_DEF,
  parameter int FRAC_BITS   = spq_pkg::FRAC_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  spq_pitch_if.sink  pitch_i,
  spq_note_if.source note_o,
  spq_cfg_if.sink    cfg_i
);
  import spq_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [9:0] {
    ST_IDLE   = 10'b00_0000_0001,
    ST_INIT   = 10'b00_0000_0010,
    ST_STEP   = 10'b00_0000_0100,
    ST_EVAL   = 10'b00_0000_1000,
    ST_SRCH   = 10'b00_0001_0000,
    ST_CMP    = 10'b00_0010_0000,
    ST_FIN    = 10'b00_0100_0000,
    ST_GOT_UP = 10'b00_1000_0000,
    ST_GOT_DN = 10'b01_0000_0000,
    ST_EMIT   = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;

  logic [KEY_W-1:0]  key_root_q;
  logic              chromatic_q;
  logic [FREQ_W-1:0] min_freq_q, max_freq_q;
  logic              stale_q, stale_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [CW-1:0]     lo_q, lo_d, hi_q, hi_d, mid_q, mid_d, idx_q, idx_d;
  logic              pair_q, pair_d;
  logic [FREQ_W-1:0] pitch_q, pitch_d;
  logic [FREQ_W-1:0] up_q, up_d;
  logic [FREQ_W-1:0] res_freq_q, res_freq_d;
  logic [CW-1:0]     res_idx_q, res_idx_d;
  logic              res_empty_q, res_empty_d;
  logic              out_valid_q, out_valid_d;
  logic [FREQ_W-1:0] out_freq_q, out_freq_d;
  logic [SLOT_W-1:0] out_slot_q, out_slot_d;
  logic              out_empty_q, out_empty_d;

  logic [CW-1:0]     mid;
  logic [CW-1:0]     fin_idx;
  logic [FREQ_W-1:0] up_diff, dn_diff;
  logic              in_acc, out_acc, cfg_acc;

  gen_ctl_t          gen_ctl;
  logic [FREQ_W-1:0] gen_freq;
  logic              gen_ovf;

  logic              ram_we;
  logic [AW-1:0]     ram_raddr;
  logic [FREQ_W-1:0] ram_rdata;

  assign pitch_i.ready = (state_q == ST_IDLE);
  assign cfg_i.ready   = 1'b1;
  assign in_acc        = pitch_i.valid && pitch_i.ready;
  assign out_acc       = note_o.valid && note_o.ready;
  assign cfg_acc       = cfg_i.valid && cfg_i.ready;

  assign note_o.valid       = out_valid_q;
  assign note_o.note_freq   = out_freq_q;
  assign note_o.note_slot   = out_slot_q;
  assign note_o.table_empty = out_empty_q;

  assign mid     = lo_q + ((hi_q - lo_q) >> 1);
  assign fin_idx = (lo_q >= cnt_q) ? cnt_q - CW'(1) : lo_q;
  assign up_diff = up_q - pitch_q;
  assign dn_diff = pitch_q - ram_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_root_q  <= '0;
      chromatic_q <= 1'b0;
      min_freq_q  <= MIN_FREQ_RST;
      max_freq_q  <= MAX_FREQ_RST;
    end else if (cfg_acc) begin
      case (cfg_i.index)
        REG_KEY_ROOT:  key_root_q  <= cfg_i.data[KEY_W-1:0];
        REG_CHROMATIC: chromatic_q <= cfg_i.data[0];
        REG_MIN_FREQ:  min_freq_q  <= cfg_i.data[FREQ_W-1:0];
        REG_MAX_FREQ:  max_freq_q  <= cfg_i.data[FREQ_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d     = state_q;
    stale_d     = stale_q;
    cnt_d       = cnt_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    idx_d       = idx_q;
    pair_d      = pair_q;
    pitch_d     = pitch_q;
    up_d        = up_q;
    res_freq_d  = res_freq_q;
    res_idx_d   = res_idx_q;
    res_empty_d = res_empty_q;
    out_valid_d = out_valid_q && !out_acc;
    out_freq_d  = out_freq_q;
    out_slot_d  = out_slot_q;
    out_empty_d = out_empty_q;
    gen_ctl.start     = 1'b0;
    gen_ctl.adv       = 1'b0;
    gen_ctl.chromatic = chromatic_q;
    gen_ctl.key_root  = key_root_q;
    ram_we    = 1'b0;
    ram_raddr = '0;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          pitch_d = pitch_i.pitch_in;
          lo_d    = '0;
          hi_d    = cnt_q;
          state_d = (stale_q || cfg_acc) ? ST_INIT : ST_SRCH;
        end
      end
      ST_INIT: begin
        gen_ctl.start = 1'b1;
        cnt_d   = '0;
        state_d = ST_STEP;
      end
      ST_STEP: begin
        gen_ctl.adv = 1'b1;
        state_d = ST_EVAL;
      end
      ST_EVAL: begin
        if (gen_ovf || gen_freq >= max_freq_q) begin
          stale_d = 1'b0;
          lo_d    = '0;
          hi_d    = cnt_q;
          state_d = ST_SRCH;
        end else begin
          gen_ctl.adv = 1'b1;
          if (gen_freq > min_freq_q && cnt_q < CW'(TABLE_DEPTH)) begin
            ram_we = 1'b1;
            cnt_d  = cnt_q + CW'(1);
          end
        end
      end
      ST_SRCH: begin
        ram_raddr = mid[AW-1:0];
        if (lo_q < hi_q) begin
          mid_d   = mid;
          state_d = ST_CMP;
        end else begin
          state_d = ST_FIN;
        end
      end
      ST_CMP: begin
        if (ram_rdata < pitch_q) begin
          lo_d = mid_q + CW'(1);
        end else begin
          hi_d = mid_q;
        end
        state_d = ST_SRCH;
      end
      ST_FIN: begin
        ram_raddr = fin_idx[AW-1:0];
        if (cnt_q == '0) begin
          res_freq_d  = '0;
          res_idx_d   = '0;
          res_empty_d = 1'b1;
          state_d     = ST_EMIT;
        end else begin
          idx_d   = fin_idx;
          pair_d  = (lo_q < cnt_q) && (lo_q != '0);
          state_d = ST_GOT_UP;
        end
      end
      ST_GOT_UP: begin
        ram_raddr = AW'(idx_q - CW'(1));
        if (!pair_q) begin
          res_freq_d  = ram_rdata;
          res_idx_d   = idx_q;
          res_empty_d = 1'b0;
          state_d     = ST_EMIT;
        end else begin
          up_d    = ram_rdata;
          state_d = ST_GOT_DN;
        end
      end
      ST_GOT_DN: begin
        res_empty_d = 1'b0;
        if (up_diff > dn_diff) begin
          res_freq_d = ram_rdata;
          res_idx_d  = idx_q - CW'(1);
        end else begin
          res_freq_d = up_q;
          res_idx_d  = idx_q;
        end
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid_q || note_o.ready) begin
          out_valid_d = 1'b1;
          out_freq_d  = res_freq_q;
          out_slot_d  = SLOT_W'(res_idx_q);
          out_empty_d = res_empty_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (cfg_acc) begin
      stale_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      stale_q     <= 1'b1;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      stale_q     <= stale_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q        <= lo_d;
    hi_q        <= hi_d;
    mid_q       <= mid_d;
    idx_q       <= idx_d;
    pair_q      <= pair_d;
    pitch_q     <= pitch_d;
    up_q        <= up_d;
    res_freq_q  <= res_freq_d;
    res_idx_q   <= res_idx_d;
    res_empty_q <= res_empty_d;
    out_freq_q  <= out_freq_d;
    out_slot_q  <= out_slot_d;
    out_empty_q <= out_empty_d;
  end

  spq_note_gen #(
    .FRAC_BITS(FRAC_BITS)
  ) u_note_gen (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (gen_ctl),
    .freq_o (gen_freq),
    .ovf_o  (gen_ovf)
  );

  spq_ram #(
    .WIDTH(FREQ_W),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cnt_q[AW-1:0]),
    .wdata_i (gen_freq),
    .re_i    (1'b1),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(TABLE_DEPTH))
    else $error("note count beyond table depth");

  a_write_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == ST_EVAL) && (cnt_q < CW'(TABLE_DEPTH)))
    else $error("table write outside build or past depth");

  a_stale_rebuild: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && stale_q && !cfg_acc) |=> (state_q == ST_INIT))
    else $error("stale table not rebuilt");

  a_search_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SRCH) |-> (lo_q <= hi_q) && (hi_q <= cnt_q))
    else $error("search window out of range");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (note_o.valid && note_o.table_empty) |-> (note_o.note_freq == '0) &&
      (note_o.note_slot == '0))
    else $error("empty-table word carries payload");
`endif

endmodule
